/* rtl/core/i8wtcim_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8wtcim_pkg
// Shared types and constants for the INT8 weight tile to CIM word mapper.
// ----------------------------------------------------------------------------
package i8wtcim_pkg;

    // Tile geometry
    localparam int TILE_LANES = 16;
    localparam int TILE_K     = 64;
    localparam int PLANES     = 8;

    // Storage: one row per Q, holding the two K columns (63-Q and 31-Q) of every lane
    localparam int ROWS      = TILE_K / 2;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int SLOTS     = 2 * TILE_LANES;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int ROW_BITS  = SLOTS * PLANES;
    localparam int PLANE_W   = $clog2(PLANES);

    // Beat field widths
    localparam int LANE_W    = 4;
    localparam int KIDX_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 8;
    localparam int WORD_W    = 32;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // Command carried in tuser
    typedef enum logic [0:0] {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } t_cmd;

    // One storage row viewed as bytes, slot 2L = upper column, 2L+1 = lower column
    typedef logic [SLOTS-1:0][PLANES-1:0] t_row;

endpackage

/* rtl/core/i8wtcim_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i8wtcim_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module i8wtcim_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read-first registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/int8_weight_tile_to_cim_words_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_weight_tile_to_cim_words_core
// Holds a 16 x 64 INT8 weight tile and serves it as 256 bit-plane CIM words.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while no read stalls. The tile lives in a
// 32 x 256-bit RAM with one row per Q: a row holds, for every lane, the bytes at
// K = 63-Q and K = 31-Q. A load reads its row, merges the byte and writes the row
// back in the next cycle; a read fetches the row and picks bit R of each of its
// 32 bytes. Each beat costs one RAM access, so the sustained rate is one beat per
// cycle without stalls; a read result passes the stage 1 and output registers.
// A row written in the previous cycle is forwarded to the merge stage. Only a
// read stalls, and only while a result is waiting at the output. The RAM has no
// reset; a read of a row that was never fully loaded returns undefined bits.
// ----------------------------------------------------------------------------
module int8_weight_tile_to_cim_words_core
    import i8wtcim_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // lane[3:0], k_index[9:4], weight_byte[17:10],
                                              // word_address[25:18], zero[31:26]
    input  logic                 i_s_tuser,  // command[0]
    // master side
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata   // cim_word[31:0], read_address[39:32]
);

    // Input beat fields
    logic [LANE_W-1:0]  in_lane;
    logic [KIDX_W-1:0]  in_kidx;
    logic [BYTE_W-1:0]  in_byte;
    logic [ADDR_W-1:0]  in_addr;
    t_cmd               in_cmd;
    logic [ROW_AW-1:0]  in_row;

    assign in_lane = i_s_tdata[3:0];
    assign in_kidx = i_s_tdata[9:4];
    assign in_byte = i_s_tdata[17:10];
    assign in_addr = i_s_tdata[25:18];
    assign in_cmd  = t_cmd'(i_s_tuser);

    // Row select: reads by Q, loads by ~k[4:0] (Q = 63-k or 31-k)
    assign in_row = (in_cmd == CMD_READ) ? in_addr[ADDR_W-1:PLANE_W]
                                         : ~in_kidx[ROW_AW-1:0];

    // Stage 1 registers (RAM read in flight)
    logic               r_s1_valid;
    t_cmd               r_s1_cmd;
    logic [ROW_AW-1:0]  r_s1_row;
    logic [SLOT_W-1:0]  r_s1_slot;
    logic [BYTE_W-1:0]  r_s1_byte;
    logic [ADDR_W-1:0]  r_s1_addr;

    // Forwarding of the row written last cycle
    logic               r_fwd_valid;
    logic [ROW_AW-1:0]  r_fwd_row;
    t_row               r_fwd_data;

    // Output register
    logic               r_out_valid;
    logic [WORD_W-1:0]  r_out_word;
    logic [ADDR_W-1:0]  r_out_addr;

    logic               s1_adv;
    logic               s_ready;
    logic               ram_we;
    logic [ROW_AW-1:0]  ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;
    t_row               base_row;
    t_row               merged_row;
    logic [WORD_W-1:0]  n_word;

    // Handshake: only a read waits, and only on a full output register
    assign s1_adv  = (r_s1_cmd == CMD_LOAD) || !r_out_valid || i_m_tready;
    assign s_ready = !r_s1_valid || s1_adv;
    assign ram_we  = r_s1_valid && (r_s1_cmd == CMD_LOAD);

    // Re-issue the held row while stalled so the read data stays live
    assign ram_raddr = (r_s1_valid && !s1_adv) ? r_s1_row : in_row;

    i8wtcim_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_row),
        .i_wdata (merged_row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Row as seen by stage 1, with write-back forwarding
    always_comb begin
        if (r_fwd_valid && (r_fwd_row == r_s1_row)) begin
            base_row = r_fwd_data;
        end else begin
            base_row = t_row'(ram_rdata);
        end
        merged_row            = base_row;
        merged_row[r_s1_slot] = r_s1_byte;
    end

    // Pick bit R of every byte in the row
    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            n_word[s] = base_row[s][r_s1_addr[PLANE_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_ready) begin
                r_s1_valid <= i_s_tvalid;
            end
            r_fwd_valid <= ram_we;
            if (r_s1_valid && (r_s1_cmd == CMD_READ) && s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_ready && i_s_tvalid) begin
            r_s1_cmd  <= in_cmd;
            r_s1_row  <= in_row;
            r_s1_slot <= {in_lane, ~in_kidx[KIDX_W-1]};
            r_s1_byte <= in_byte;
            r_s1_addr <= in_addr;
        end
        if (ram_we) begin
            r_fwd_row  <= r_s1_row;
            r_fwd_data <= merged_row;
        end
        if (r_s1_valid && (r_s1_cmd == CMD_READ) && s1_adv) begin
            r_out_word <= n_word;
            r_out_addr <= r_s1_addr;
        end
    end

    assign o_s_tready = s_ready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_addr, r_out_word};

    // A read leaving stage 1 shows up at the output with its address
    a_read_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_cmd == CMD_READ) && s1_adv)
        |=> (r_out_valid && (r_out_addr == $past(r_s1_addr))))
        else $error("read did not reach output register");

    // A stalled stage 1 keeps its row and stays valid
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_row)))
        else $error("stalled stage 1 lost its row");

    // Forwarded row always comes from the write in the previous cycle
    a_fwd_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_cmd == CMD_LOAD)) |=> (r_fwd_valid && (r_fwd_row == $past(r_s1_row))))
        else $error("forwarding register missed a write-back");

endmodule
